>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers, clocked on clk with rst_n as the disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/lef_pkg.sv
// ----------------------------------------------------------------------------
// lef_pkg
// Constants, register map and gray conversion for the Laplacian edge filter.
// ----------------------------------------------------------------------------
package lef_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned CFG_W = 11;
  localparam int unsigned ROW_W = 11;
  localparam int unsigned SUM_W = 13;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd1024;
  localparam logic [ROW_W-1:0] ROW_MAX      = 11'h7FF;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  // floor(x/3) for x <= 765 via reciprocal 683/2048
  function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] r,
                                               input logic [PIX_W-1:0] g,
                                               input logic [PIX_W-1:0] b);
    logic [9:0]  s;
    logic [19:0] p;
    s = 10'(r) + 10'(g) + 10'(b);
    p = 20'(s) * 20'd683;
    return p[18:11];
  endfunction

endpackage

>>> rtl/laplacian_edge_filter_3x3.sv
// ----------------------------------------------------------------------------
// laplacian_edge_filter_3x3
// 3x3 Laplacian edge filter over a raster RGB stream with two line stores.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one RGB pixel per word, raster order; in_tuser set marks a pad
//           word used to drain the last row after the frame's pixels.
//           Pad words arriving before the frame is complete are dropped.
//   out_* : one result per pixel, edge value in tdata, border flag in tuser,
//           tlast on the frame's last pixel.
//   cfg_* : frame_width at 0x0, frame_height at 0x4; write only while idle.
// Throughput: one word per clock, sustained while out_tready is high; the line
//   stores are read on accept and written as the word leaves the read stage,
//   with a bypass when consecutive words hit the same column.
// Results: a result for a pixel is produced by the word frame_width+1 words
//   later; that word passes the read stage and then the output register.
// Reset: counters, window and valid flags clear at once; line stores are
//   not cleared and need no sweep, since unwritten entries feed only border
//   results.
// Stall: while out_tready is low the output register holds; words enter the
//   read stage until a result word waits, then in_tready drops until drained.
// ----------------------------------------------------------------------------
module laplacian_edge_filter_3x3 #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // red [7:0], green [15:8], blue [23:16]
  input  logic [0:0]  in_tuser,    // pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // edge_value [7:0]
  output logic [0:0]  out_tuser,   // is_border
  output logic        out_tlast,   // end_of_frame
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned XW = (CW + 1 > 12) ? CW + 1 : 12;
  localparam int unsigned PW = lef_pkg::PIX_W;
  localparam int unsigned RW = lef_pkg::ROW_W;
  localparam int unsigned SW = lef_pkg::SUM_W;

  // ---------------- configuration ----------------
  logic [lef_pkg::CFG_W-1:0] width_r, height_r;
  lef_pkg::reg_idx_t         cfg_sel;
  logic                      cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = lef_pkg::reg_idx_t'(cfg_paddr[2]);
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lef_pkg::WIDTH_RESET;
      height_r <= lef_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        lef_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_pwdata[lef_pkg::CFG_W-1:0];
        lef_pkg::REG_FRAME_HEIGHT: height_r <= cfg_pwdata[lef_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      lef_pkg::REG_FRAME_WIDTH:  cfg_prdata = 32'(width_r);
      lef_pkg::REG_FRAME_HEIGHT: cfg_prdata = 32'(height_r);
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- position and classification ----------------
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [XW-1:0] eff_w, wid_x, col_x, cc;
  logic [RW-1:0] eff_h, cr;
  logic          drain, skip, take, has_res, bord, eof;
  logic [PW-1:0] gray0;

  always_comb begin
    wid_x = XW'(width_r);
    if (wid_x == '0)                    eff_w = XW'(1);
    else if (wid_x > XW'(MAX_WIDTH))    eff_w = XW'(MAX_WIDTH);
    else                                eff_w = wid_x;
    eff_h = (height_r == '0) ? RW'(1) : RW'(height_r);
    col_x = XW'(col_r);

    drain = row_r >= eff_h;
    skip  = in_tuser[0] && !drain;
    gray0 = drain ? '0 : lef_pkg::gray_of(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);

    has_res = (row_r >= RW'(2)) || ((row_r == RW'(1)) && (col_r != '0));
    cr      = (col_r != '0) ? row_r - RW'(1) : row_r - RW'(2);
    cc      = (col_r != '0) ? col_x - XW'(1) : eff_w - XW'(1);
    bord    = (cr == '0) || (cr >= eff_h - RW'(1)) || (cc == '0) || (cc >= eff_w - XW'(1));
    eof     = (cr >= eff_h - RW'(1)) && (cc >= eff_w - XW'(1));
  end

  assign take = in_tvalid && in_tready && !skip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (take) begin
      if (has_res && eof) begin
        col_r <= '0;
        row_r <= '0;
      end else if (col_x + XW'(1) >= eff_w) begin
        col_r <= '0;
        if (row_r != lef_pkg::ROW_MAX) row_r <= row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // ---------------- read stage ----------------
  logic [PW-1:0] upper_mem  [MAX_WIDTH];
  logic [PW-1:0] middle_mem [MAX_WIDTH];

  logic          s1_v_r, s1_res_r, s1_bord_r, s1_eof_r, s1_fwd_r;
  logic [CW-1:0] s1_idx_r;
  logic [PW-1:0] s1_g_r, rd_up_r, rd_mid_r, fwd_top_r, fwd_mid_r;
  logic [PW-1:0] top_e, mid_e;
  logic          s1_adv;

  logic          out_v_r;
  logic [PW-1:0] out_val_r;
  logic          out_bord_r, out_eof_r;

  assign top_e     = s1_fwd_r ? fwd_top_r : rd_up_r;
  assign mid_e     = s1_fwd_r ? fwd_mid_r : rd_mid_r;
  assign s1_adv    = s1_v_r && (!s1_res_r || !out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;

  // line stores: read on accept, written as the word leaves the read stage
  always_ff @(posedge clk) begin
    if (take) begin
      rd_up_r  <= upper_mem[col_r];
      rd_mid_r <= middle_mem[col_r];
    end
    if (s1_adv) begin
      upper_mem[s1_idx_r]  <= mid_e;
      middle_mem[s1_idx_r] <= s1_g_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s1_fwd_r <= 1'b0;
    end else begin
      if (take) begin
        s1_v_r   <= 1'b1;
        // same column as the word being written now: the read saw stale data
        s1_fwd_r <= s1_adv && (s1_idx_r == col_r);
      end else if (s1_adv) begin
        s1_v_r   <= 1'b0;
        s1_fwd_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_idx_r  <= col_r;
      s1_g_r    <= gray0;
      s1_res_r  <= has_res;
      s1_bord_r <= bord;
      s1_eof_r  <= eof;
      fwd_top_r <= mid_e;
      fwd_mid_r <= s1_g_r;
    end
  end

  // ---------------- window and Laplacian ----------------
  logic [PW-1:0]        win_r [6];
  logic signed [SW-1:0] lap;
  logic [PW-1:0]        edge_val;

  always_comb begin
    lap = (SW'(win_r[4]) <<< 3)
        - SW'(win_r[0]) - SW'(win_r[1]) - SW'(win_r[2])
        - SW'(win_r[3]) - SW'(win_r[5])
        - SW'(top_e) - SW'(mid_e) - SW'(s1_g_r);
    priority if (s1_bord_r)         edge_val = win_r[4];
    else if (lap > SW'(255))        edge_val = 8'd255;
    else if (lap < 0)               edge_val = 8'd0;
    else                            edge_val = lap[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (s1_adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_e;
      win_r[4] <= mid_e;
      win_r[5] <= s1_g_r;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv && s1_res_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_res_r) begin
      out_val_r  <= edge_val;
      out_bord_r <= s1_bord_r;
      out_eof_r  <= s1_eof_r;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_val_r;
  assign out_tuser[0] = out_bord_r;
  assign out_tlast    = out_eof_r;

  // ---------------- assertions ----------------
`include "assert_macros.svh"

  `ASSERT_IMPL(a_ready_when_empty, !s1_v_r, in_tready)
  `ASSERT_IMPL(a_fwd_needs_word, s1_fwd_r, s1_v_r)
  `ASSERT_IMPL(a_hold_on_stall, s1_v_r && s1_res_r && out_v_r && !out_tready, !in_tready)
  `ASSERT_NEXT(a_eof_rewinds, take && has_res && eof, col_r == '0 && row_r == '0)

endmodule
